// ----- hw/rtl/kcaf_pkg.sv -----
// ============================================================================
// kcaf_pkg
// Shared types, Q23.40 constants, saturation helpers and the microprogram
// for the constant-acceleration Kalman filter.
// ============================================================================
package kcaf_pkg;

   localparam int KCAF_WORD_W   = 64;
   localparam int KCAF_RF_DEPTH = 64;
   localparam int KCAF_RF_AW    = 6;
   localparam int KCAF_PC_W     = 7;
   localparam int KCAF_CSR_IW   = 8;

   // configuration register indexes
   localparam logic [KCAF_CSR_IW-1:0] CSR_PROCESS_NOISE     = 8'd0;
   localparam logic [KCAF_CSR_IW-1:0] CSR_MEASUREMENT_NOISE = 8'd1;
   localparam logic [KCAF_CSR_IW-1:0] CSR_DEFAULT_STEP      = 8'd2;
   localparam logic [KCAF_CSR_IW-1:0] CSR_ENABLE            = 8'd3;

   // Q23.40 constants
   localparam logic [63:0] FX_ONE       = 64'd1099511627776;
   localparam logic [63:0] FX_HALF      = 64'd549755813888;
   localparam logic [63:0] FX_EIGHTH    = 64'd137438953472;
   localparam logic [63:0] FX_TWENTIETH = 64'd54975581389;
   localparam logic [63:0] FX_SIXTH     = 64'd183251937963;
   localparam logic [63:0] FX_THIRD     = 64'd366503875925;
   localparam logic [63:0] FX_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FX_MIN       = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MOV
   } kcaf_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_WAIT,
      ST_DONE
   } kcaf_state_type;

   // operand code: bit 6 clear = register file address, set = special source
   typedef logic [6:0] kcaf_opnd_type;

   localparam kcaf_opnd_type R_EP   = 7'd0;
   localparam kcaf_opnd_type R_EV   = 7'd1;
   localparam kcaf_opnd_type R_EA   = 7'd2;
   localparam kcaf_opnd_type R_P11  = 7'd3;
   localparam kcaf_opnd_type R_P12  = 7'd4;
   localparam kcaf_opnd_type R_P13  = 7'd5;
   localparam kcaf_opnd_type R_P22  = 7'd6;
   localparam kcaf_opnd_type R_P23  = 7'd7;
   localparam kcaf_opnd_type R_P33  = 7'd8;
   localparam kcaf_opnd_type R_W2   = 7'd9;
   localparam kcaf_opnd_type R_V2   = 7'd10;
   localparam kcaf_opnd_type R_D2   = 7'd11;
   localparam kcaf_opnd_type R_D3   = 7'd12;
   localparam kcaf_opnd_type R_D4   = 7'd13;
   localparam kcaf_opnd_type R_D5   = 7'd14;
   localparam kcaf_opnd_type R_Q11  = 7'd15;
   localparam kcaf_opnd_type R_Q12  = 7'd16;
   localparam kcaf_opnd_type R_Q13  = 7'd17;
   localparam kcaf_opnd_type R_Q22  = 7'd18;
   localparam kcaf_opnd_type R_Q23  = 7'd19;
   localparam kcaf_opnd_type R_Q33  = 7'd20;
   localparam kcaf_opnd_type R_T7   = 7'd21;
   localparam kcaf_opnd_type R_P33D = 7'd22;
   localparam kcaf_opnd_type R_T9   = 7'd23;
   localparam kcaf_opnd_type R_M11  = 7'd24;
   localparam kcaf_opnd_type R_M12  = 7'd25;
   localparam kcaf_opnd_type R_M13  = 7'd26;
   localparam kcaf_opnd_type R_M22  = 7'd27;
   localparam kcaf_opnd_type R_M23  = 7'd28;
   localparam kcaf_opnd_type R_M33  = 7'd29;
   localparam kcaf_opnd_type R_S    = 7'd30;
   localparam kcaf_opnd_type R_PP   = 7'd31;
   localparam kcaf_opnd_type R_VP   = 7'd32;
   localparam kcaf_opnd_type R_E    = 7'd33;
   localparam kcaf_opnd_type R_K1   = 7'd34;
   localparam kcaf_opnd_type R_K2   = 7'd35;
   localparam kcaf_opnd_type R_K3   = 7'd36;
   localparam kcaf_opnd_type R_OM   = 7'd37;
   localparam kcaf_opnd_type R_T0   = 7'd38;
   localparam kcaf_opnd_type R_T1   = 7'd39;
   localparam kcaf_opnd_type R_T2   = 7'd40;

   localparam kcaf_opnd_type S_Z    = 7'h40;
   localparam kcaf_opnd_type S_D    = 7'h41;
   localparam kcaf_opnd_type S_WQ   = 7'h42;
   localparam kcaf_opnd_type S_VQ   = 7'h43;
   localparam kcaf_opnd_type S_ZERO = 7'h44;
   localparam kcaf_opnd_type S_ONE  = 7'h45;
   localparam kcaf_opnd_type S_HALF = 7'h46;
   localparam kcaf_opnd_type S_C8   = 7'h47;
   localparam kcaf_opnd_type S_C20  = 7'h48;
   localparam kcaf_opnd_type S_C6   = 7'h49;
   localparam kcaf_opnd_type S_C3   = 7'h4A;

   typedef struct packed {
      kcaf_op_type             op;
      logic                    first_only;
      logic [KCAF_RF_AW-1:0]   dst;
      kcaf_opnd_type           opa;
      kcaf_opnd_type           opb;
   } kcaf_ins_type;

   localparam logic [KCAF_PC_W-1:0] KCAF_NUM_INS = 7'd95;

   function automatic kcaf_ins_type kcaf_ins(input kcaf_op_type op, input kcaf_opnd_type dst,
                                             input kcaf_opnd_type a, input kcaf_opnd_type b,
                                             input logic fo);
      kcaf_ins_type r;
      r.op         = op;
      r.first_only = fo;
      r.dst        = dst[KCAF_RF_AW-1:0];
      r.opa        = a;
      r.opb        = b;
      return r;
   endfunction

   function automatic logic [63:0] kcaf_mag(input logic [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic logic [63:0] kcaf_sat(input logic [63:0] mag, input logic neg,
                                            input logic ovf);
      logic [63:0] r;
      if (!neg) begin
         r = (ovf || mag[63]) ? FX_MAX : mag;
      end else begin
         r = (ovf || mag[63]) ? FX_MIN : (~mag + 64'd1);
      end
      return r;
   endfunction

   // microprogram: predict, gain, correct
   function automatic kcaf_ins_type kcaf_ucode(input logic [KCAF_PC_W-1:0] pc);
      kcaf_ins_type r;
      unique case (pc)
         7'd0:  r = kcaf_ins(OP_MUL, R_W2,   S_WQ,   S_WQ,   1'b0);
         7'd1:  r = kcaf_ins(OP_MUL, R_V2,   S_VQ,   S_VQ,   1'b0);
         7'd2:  r = kcaf_ins(OP_MUL, R_D2,   S_D,    S_D,    1'b0);
         7'd3:  r = kcaf_ins(OP_MUL, R_D3,   R_D2,   S_D,    1'b0);
         7'd4:  r = kcaf_ins(OP_MUL, R_D4,   R_D2,   R_D2,   1'b0);
         7'd5:  r = kcaf_ins(OP_MUL, R_D5,   R_D4,   S_D,    1'b0);
         7'd6:  r = kcaf_ins(OP_MUL, R_T0,   R_D5,   S_C20,  1'b0);
         7'd7:  r = kcaf_ins(OP_MUL, R_Q11,  R_T0,   R_W2,   1'b0);
         7'd8:  r = kcaf_ins(OP_MUL, R_T0,   R_D4,   S_C8,   1'b0);
         7'd9:  r = kcaf_ins(OP_MUL, R_Q12,  R_T0,   R_W2,   1'b0);
         7'd10: r = kcaf_ins(OP_MUL, R_T0,   R_D3,   S_C6,   1'b0);
         7'd11: r = kcaf_ins(OP_MUL, R_Q13,  R_T0,   R_W2,   1'b0);
         7'd12: r = kcaf_ins(OP_MUL, R_T0,   R_D3,   S_C3,   1'b0);
         7'd13: r = kcaf_ins(OP_MUL, R_Q22,  R_T0,   R_W2,   1'b0);
         7'd14: r = kcaf_ins(OP_MUL, R_T0,   R_D2,   S_HALF, 1'b0);
         7'd15: r = kcaf_ins(OP_MUL, R_Q23,  R_T0,   R_W2,   1'b0);
         7'd16: r = kcaf_ins(OP_MUL, R_Q33,  S_D,    R_W2,   1'b0);
         // seeding on the first sample
         7'd17: r = kcaf_ins(OP_MOV, R_EP,   S_Z,    S_ZERO, 1'b1);
         7'd18: r = kcaf_ins(OP_MOV, R_EV,   S_ZERO, S_ZERO, 1'b1);
         7'd19: r = kcaf_ins(OP_MOV, R_EA,   S_ZERO, S_ZERO, 1'b1);
         7'd20: r = kcaf_ins(OP_MOV, R_P11,  R_Q11,  S_ZERO, 1'b1);
         7'd21: r = kcaf_ins(OP_MOV, R_P12,  R_Q12,  S_ZERO, 1'b1);
         7'd22: r = kcaf_ins(OP_MOV, R_P13,  R_Q13,  S_ZERO, 1'b1);
         7'd23: r = kcaf_ins(OP_MOV, R_P22,  R_Q22,  S_ZERO, 1'b1);
         7'd24: r = kcaf_ins(OP_MOV, R_P23,  R_Q23,  S_ZERO, 1'b1);
         7'd25: r = kcaf_ins(OP_MOV, R_P33,  R_Q33,  S_ZERO, 1'b1);
         // predicted covariance
         7'd26: r = kcaf_ins(OP_MUL, R_T7,   R_P23,  S_D,    1'b0);
         7'd27: r = kcaf_ins(OP_MUL, R_P33D, R_P33,  S_D,    1'b0);
         7'd28: r = kcaf_ins(OP_MUL, R_T0,   R_P33,  R_D2,   1'b0);
         7'd29: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd30: r = kcaf_ins(OP_ADD, R_T1,   R_P13,  R_T7,   1'b0);
         7'd31: r = kcaf_ins(OP_ADD, R_T9,   R_T1,   R_T0,   1'b0);
         7'd32: r = kcaf_ins(OP_MUL, R_T0,   R_P12,  S_D,    1'b0);
         7'd33: r = kcaf_ins(OP_ADD, R_T1,   R_P11,  R_T0,   1'b0);
         7'd34: r = kcaf_ins(OP_MUL, R_T0,   R_D2,   R_T9,   1'b0);
         7'd35: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd36: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_T0,   1'b0);
         7'd37: r = kcaf_ins(OP_MUL, R_T0,   R_P13,  R_D2,   1'b0);
         7'd38: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd39: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_T0,   1'b0);
         7'd40: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_Q11,  1'b0);
         7'd41: r = kcaf_ins(OP_MUL, R_T2,   R_P22,  S_D,    1'b0);
         7'd42: r = kcaf_ins(OP_ADD, R_T2,   R_P12,  R_T2,   1'b0);
         7'd43: r = kcaf_ins(OP_MUL, R_T0,   R_P23,  R_D2,   1'b0);
         7'd44: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd45: r = kcaf_ins(OP_ADD, R_T2,   R_T2,   R_T0,   1'b0);
         7'd46: r = kcaf_ins(OP_MUL, R_T0,   S_D,    R_T2,   1'b0);
         7'd47: r = kcaf_ins(OP_ADD, R_M11,  R_T1,   R_T0,   1'b0);
         7'd48: r = kcaf_ins(OP_MUL, R_T0,   R_P13,  S_D,    1'b0);
         7'd49: r = kcaf_ins(OP_ADD, R_T1,   R_P12,  R_T0,   1'b0);
         7'd50: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_Q12,  1'b0);
         7'd51: r = kcaf_ins(OP_ADD, R_T2,   R_P23,  R_P33D, 1'b0);
         7'd52: r = kcaf_ins(OP_MUL, R_T0,   R_D2,   R_T2,   1'b0);
         7'd53: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd54: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_T0,   1'b0);
         7'd55: r = kcaf_ins(OP_ADD, R_T2,   R_P22,  R_T7,   1'b0);
         7'd56: r = kcaf_ins(OP_MUL, R_T0,   S_D,    R_T2,   1'b0);
         7'd57: r = kcaf_ins(OP_ADD, R_M12,  R_T1,   R_T0,   1'b0);
         7'd58: r = kcaf_ins(OP_ADD, R_M13,  R_T9,   R_Q13,  1'b0);
         7'd59: r = kcaf_ins(OP_ADD, R_T1,   R_P22,  R_T7,   1'b0);
         7'd60: r = kcaf_ins(OP_ADD, R_T2,   R_P23,  R_P33D, 1'b0);
         7'd61: r = kcaf_ins(OP_MUL, R_T0,   S_D,    R_T2,   1'b0);
         7'd62: r = kcaf_ins(OP_ADD, R_T1,   R_T1,   R_T0,   1'b0);
         7'd63: r = kcaf_ins(OP_ADD, R_M22,  R_T1,   R_Q22,  1'b0);
         7'd64: r = kcaf_ins(OP_ADD, R_T1,   R_P23,  R_P33D, 1'b0);
         7'd65: r = kcaf_ins(OP_ADD, R_M23,  R_T1,   R_Q23,  1'b0);
         7'd66: r = kcaf_ins(OP_ADD, R_M33,  R_P33,  R_Q33,  1'b0);
         // predicted state, innovation, gains
         7'd67: r = kcaf_ins(OP_MUL, R_T0,   S_D,    R_EV,   1'b0);
         7'd68: r = kcaf_ins(OP_ADD, R_T1,   R_EP,   R_T0,   1'b0);
         7'd69: r = kcaf_ins(OP_MUL, R_T0,   R_EA,   R_D2,   1'b0);
         7'd70: r = kcaf_ins(OP_MUL, R_T0,   R_T0,   S_HALF, 1'b0);
         7'd71: r = kcaf_ins(OP_ADD, R_PP,   R_T1,   R_T0,   1'b0);
         7'd72: r = kcaf_ins(OP_MUL, R_T0,   R_EA,   S_D,    1'b0);
         7'd73: r = kcaf_ins(OP_ADD, R_VP,   R_EV,   R_T0,   1'b0);
         7'd74: r = kcaf_ins(OP_SUB, R_E,    R_PP,   S_Z,    1'b0);
         7'd75: r = kcaf_ins(OP_ADD, R_S,    R_M11,  R_V2,   1'b0);
         7'd76: r = kcaf_ins(OP_DIV, R_K1,   R_M11,  R_S,    1'b0);
         7'd77: r = kcaf_ins(OP_DIV, R_K2,   R_M12,  R_S,    1'b0);
         7'd78: r = kcaf_ins(OP_DIV, R_K3,   R_M13,  R_S,    1'b0);
         // state correction
         7'd79: r = kcaf_ins(OP_MUL, R_T0,   R_E,    R_K1,   1'b0);
         7'd80: r = kcaf_ins(OP_SUB, R_EP,   R_PP,   R_T0,   1'b0);
         7'd81: r = kcaf_ins(OP_MUL, R_T0,   R_E,    R_K2,   1'b0);
         7'd82: r = kcaf_ins(OP_SUB, R_EV,   R_VP,   R_T0,   1'b0);
         7'd83: r = kcaf_ins(OP_MUL, R_T0,   R_E,    R_K3,   1'b0);
         7'd84: r = kcaf_ins(OP_SUB, R_EA,   R_EA,   R_T0,   1'b0);
         // covariance correction
         7'd85: r = kcaf_ins(OP_SUB, R_OM,   S_ONE,  R_K1,   1'b0);
         7'd86: r = kcaf_ins(OP_MUL, R_P11,  R_M11,  R_OM,   1'b0);
         7'd87: r = kcaf_ins(OP_MUL, R_P12,  R_M12,  R_OM,   1'b0);
         7'd88: r = kcaf_ins(OP_MUL, R_P13,  R_M13,  R_OM,   1'b0);
         7'd89: r = kcaf_ins(OP_MUL, R_T0,   R_K2,   R_M12,  1'b0);
         7'd90: r = kcaf_ins(OP_SUB, R_P22,  R_M22,  R_T0,   1'b0);
         7'd91: r = kcaf_ins(OP_MUL, R_T0,   R_K3,   R_M12,  1'b0);
         7'd92: r = kcaf_ins(OP_SUB, R_P23,  R_M23,  R_T0,   1'b0);
         7'd93: r = kcaf_ins(OP_MUL, R_T0,   R_K3,   R_M13,  1'b0);
         7'd94: r = kcaf_ins(OP_SUB, R_P33,  R_M33,  R_T0,   1'b0);
         default: r = kcaf_ins(OP_MOV, R_T0, S_ZERO, S_ZERO, 1'b0);
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/kalman_const_accel_filter_top.sv -----
// ============================================================================
// kalman_const_accel_filter_top
// Position/velocity/acceleration Kalman filter, one microcoded datapath.
// ============================================================================
// Usage:
//  - req_*: one transfer per sample (Q16.16 position, Q0.32 time step; a
//    zero step uses the default_step register). req_stall stays high while
//    an update runs and until its result transfer is taken.
//  - rsp_*: one transfer per sample with filtered position and velocity in
//    Q16.16 and result_valid. rsp_valid holds with a stable payload while
//    rsp_stall is high; no new sample is taken until the transfer completes.
//  - csr_*: register writes, always ready; write only while idle. Any write
//    to a known index rearms first-sample seeding; unknown indexes are dropped.
//  - Sequence: an open req transfer runs the 95 microinstructions on a 64-bit
//    register file, each through the read and execute states (multiplies and
//    divides then wait on the shared multiplier or the shared divider, which
//    is used three times); the seeding ones execute only when the sample
//    seeds the state. Then rsp_valid rises. A closed filter raises rsp_valid
//    the next cycle, all zeros.
//  - Reset: settings zero, filter closed, seeding armed. The register file
//    needs no clearing: the seeding pass writes all state before it is read.
// ============================================================================
module kalman_const_accel_filter_top
   import kcaf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_raw_position,
   input  logic [31:0]            req_time_step,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_filtered_position,
   output logic [31:0]            rsp_filtered_velocity,
   output logic                   rsp_result_valid,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [KCAF_CSR_IW-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   // Q40 to saturated Q16.16, round half away from zero
   function automatic logic [31:0] to_q16(input logic [63:0] a);
      logic [64:0] r;
      logic [31:0] s;
      r = ({1'b0, kcaf_mag(a)} + 65'd8388608) >> 24;
      if (a[63]) begin
         s = (r > 65'd2147483648) ? 32'h8000_0000 : 32'(~r[31:0] + 32'd1);
      end else begin
         s = (r > 65'd2147483647) ? 32'h7FFF_FFFF : r[31:0];
      end
      return s;
   endfunction

   kcaf_state_type state_ff, state_in;
   logic [KCAF_PC_W-1:0] pc_ff, pc_in;
   logic        pending_ff, pending_in;
   logic [31:0] w_ff, w_in, v_ff, v_in, dstep_ff, dstep_in;
   logic        enable_ff, enable_in;
   logic [63:0] z_ff, z_in, d_ff, d_in;
   logic [31:0] pos_ff, pos_in, vel_ff, vel_in;
   logic        rvalid_ff, rvalid_in;

   kcaf_ins_type ins;
   logic         filter_open;
   logic [31:0]  step_sel;
   logic [63:0]  ram_a, ram_b, val_a, val_b;
   logic [63:0]  wq, vq;
   logic         wr_en;
   logic [63:0]  wr_data;
   logic         mul_start, div_start, mul_done, div_done;
   logic [63:0]  mul_res, div_res;
   logic [64:0]  add_full, sub_full;
   logic [63:0]  add_sat, sub_sat;
   logic         csr_hit;

   assign ins = kcaf_ucode(pc_ff);
   assign wq  = {8'd0, w_ff, 24'd0};
   assign vq  = {8'd0, v_ff, 24'd0};

   // operand source select
   function automatic logic [63:0] opnd_val(input kcaf_opnd_type o, input logic [63:0] ram,
                                            input logic [63:0] z, input logic [63:0] d,
                                            input logic [63:0] w, input logic [63:0] v);
      logic [63:0] r;
      if (!o[6]) begin
         r = ram;
      end else begin
         unique case (o)
            S_Z:     r = z;
            S_D:     r = d;
            S_WQ:    r = w;
            S_VQ:    r = v;
            S_ONE:   r = FX_ONE;
            S_HALF:  r = FX_HALF;
            S_C8:    r = FX_EIGHTH;
            S_C20:   r = FX_TWENTIETH;
            S_C6:    r = FX_SIXTH;
            S_C3:    r = FX_THIRD;
            default: r = 64'd0;
         endcase
      end
      return r;
   endfunction

   assign val_a = opnd_val(ins.opa, ram_a, z_ff, d_ff, wq, vq);
   assign val_b = opnd_val(ins.opb, ram_b, z_ff, d_ff, wq, vq);

   // saturating add/sub
   assign add_full = {val_a[63], val_a} + {val_b[63], val_b};
   assign sub_full = {val_a[63], val_a} - {val_b[63], val_b};
   assign add_sat  = (add_full[64] != add_full[63]) ? (add_full[64] ? FX_MIN : FX_MAX)
                                                    : add_full[63:0];
   assign sub_sat  = (sub_full[64] != sub_full[63]) ? (sub_full[64] ? FX_MIN : FX_MAX)
                                                    : sub_full[63:0];

   assign filter_open = enable_ff && (w_ff != 32'd0) && (v_ff != 32'd0)
                        && (dstep_ff != 32'd0);
   assign step_sel    = (req_time_step == 32'd0) ? dstep_ff : req_time_step;
   assign csr_hit     = csr_valid && csr_ready;

   kcaf_ram #(.WIDTH(KCAF_WORD_W), .DEPTH(KCAF_RF_DEPTH)) u_rf (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ins.dst),
      .wr_data   (wr_data),
      .rd_addr_a (ins.opa[KCAF_RF_AW-1:0]),
      .rd_data_a (ram_a),
      .rd_addr_b (ins.opb[KCAF_RF_AW-1:0]),
      .rd_data_b (ram_b)
   );

   kcaf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (val_a),
      .op_b   (val_b),
      .result (mul_res),
      .done   (mul_done)
   );

   kcaf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .op_a   (val_a),
      .op_b   (val_b),
      .result (div_res),
      .done   (div_done)
   );

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      pending_in = pending_ff;
      w_in       = w_ff;
      v_in       = v_ff;
      dstep_in   = dstep_ff;
      enable_in  = enable_ff;
      z_in       = z_ff;
      d_in       = d_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      rvalid_in  = rvalid_ff;
      wr_en      = 1'b0;
      wr_data    = add_sat;
      mul_start  = 1'b0;
      div_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (filter_open) begin
                  z_in      = {{8{req_raw_position[31]}}, req_raw_position, 24'd0};
                  d_in      = {24'd0, step_sel, 8'd0};
                  rvalid_in = 1'b1;
                  pc_in     = '0;
                  state_in  = ST_READ;
               end else begin
                  pos_in    = '0;
                  vel_in    = '0;
                  rvalid_in = 1'b0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_READ: begin
            if (pc_ff == KCAF_NUM_INS) begin
               pending_in = 1'b0;
               state_in   = ST_DONE;
            end else if (ins.first_only && !pending_ff) begin
               pc_in = pc_ff + 7'd1;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (ins.op)
               OP_MUL: begin
                  mul_start = 1'b1;
                  state_in  = ST_WAIT;
               end
               OP_DIV: begin
                  div_start = 1'b1;
                  state_in  = ST_WAIT;
               end
               OP_SUB: begin
                  wr_en    = 1'b1;
                  wr_data  = sub_sat;
                  pc_in    = pc_ff + 7'd1;
                  state_in = ST_READ;
               end
               OP_MOV: begin
                  wr_en    = 1'b1;
                  wr_data  = val_a;
                  pc_in    = pc_ff + 7'd1;
                  state_in = ST_READ;
               end
               default: begin
                  wr_en    = 1'b1;
                  wr_data  = add_sat;
                  pc_in    = pc_ff + 7'd1;
                  state_in = ST_READ;
               end
            endcase
         end
         ST_WAIT: begin
            if ((ins.op == OP_MUL) ? mul_done : div_done) begin
               wr_en    = 1'b1;
               wr_data  = (ins.op == OP_MUL) ? mul_res : div_res;
               pc_in    = pc_ff + 7'd1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // last write of the estimate wins
      if (wr_en && ins.dst == R_EP[KCAF_RF_AW-1:0]) begin
         pos_in = to_q16(wr_data);
      end
      if (wr_en && ins.dst == R_EV[KCAF_RF_AW-1:0]) begin
         vel_in = to_q16(wr_data);
      end

      if (csr_hit) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE: begin
               w_in       = csr_data;
               pending_in = 1'b1;
            end
            CSR_MEASUREMENT_NOISE: begin
               v_in       = csr_data;
               pending_in = 1'b1;
            end
            CSR_DEFAULT_STEP: begin
               dstep_in   = csr_data;
               pending_in = 1'b1;
            end
            CSR_ENABLE: begin
               enable_in  = csr_data[0];
               pending_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pc_ff      <= '0;
         pending_ff <= 1'b1;
         w_ff       <= '0;
         v_ff       <= '0;
         dstep_ff   <= '0;
         enable_ff  <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pc_ff      <= pc_in;
         pending_ff <= pending_in;
         w_ff       <= w_in;
         v_ff       <= v_in;
         dstep_ff   <= dstep_in;
         enable_ff  <= enable_in;
         rvalid_ff  <= rvalid_in;
      end
      z_ff   <= z_in;
      d_ff   <= d_in;
      pos_ff <= pos_in;
      vel_ff <= vel_in;
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_DONE);
   assign rsp_filtered_position = pos_ff;
   assign rsp_filtered_velocity = vel_ff;
   assign rsp_result_valid      = rvalid_ff;
   assign csr_ready             = 1'b1;

endmodule

// ----- hw/rtl/kcaf_ram.sv -----
// ============================================================================
// kcaf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module kcaf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ----- hw/rtl/kcaf_mul.sv -----
// ============================================================================
// kcaf_mul
// Q23.40 multiplier: four 32x32 partial products, round half away, saturate.
// ============================================================================
module kcaf_mul
   import kcaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] result,
   output logic        done
);

   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic         neg_ff, neg_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   ppsel_ff, ppsel_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  res_ff, res_in;
   logic         done_ff, done_in;

   logic [31:0]  xs, ys;
   logic [127:0] pp_shift;
   logic [127:0] rnd;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    begin xs = x_ff[31:0];  ys = y_ff[31:0];  end
         2'd1:    begin xs = x_ff[31:0];  ys = y_ff[63:32]; end
         2'd2:    begin xs = x_ff[63:32]; ys = y_ff[31:0];  end
         default: begin xs = x_ff[63:32]; ys = y_ff[63:32]; end
      endcase
      case (ppsel_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd3:    pp_shift = {pp_ff, 64'd0};
         default: pp_shift = {32'd0, pp_ff, 32'd0};
      endcase
      rnd = acc_ff + (128'd1 << 39);

      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      pp_in    = pp_ff;
      ppsel_in = ppsel_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in    = kcaf_mag(op_a);
         y_in    = kcaf_mag(op_b);
         neg_in  = op_a[63] ^ op_b[63];
         cnt_in  = 3'd0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff <= 3'd3) begin
            pp_in    = xs * ys;
            ppsel_in = cnt_ff[1:0];
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + pp_shift;
         end
         if (cnt_ff == 3'd5) begin
            res_in  = kcaf_sat(rnd[103:40], neg_ff, |rnd[127:104]);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      pp_ff    <= pp_in;
      ppsel_ff <= ppsel_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

// ----- hw/rtl/kcaf_div.sv -----
// ============================================================================
// kcaf_div
// Q23.40 divider: (a << 40) / b, restoring, one quotient bit per cycle.
// ============================================================================
module kcaf_div
   import kcaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] result,
   output logic        done
);

   logic [127:0] dvd_ff, dvd_in;
   logic [63:0]  den_ff, den_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic         ovf_ff, ovf_in;
   logic         neg_ff, neg_in;
   logic         zero_ff, zero_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [63:0]  res_ff, res_in;
   logic         done_ff, done_in;

   logic [64:0]  rem2;
   logic         ge;

   always_comb begin
      rem2 = {rem_ff, dvd_ff[127]};
      ge   = rem2 >= {1'b0, den_ff};

      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {24'd0, kcaf_mag(op_a), 40'd0};
         den_in  = kcaf_mag(op_b);
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = op_a[63] ^ op_b[63];
         zero_in = (op_b == 64'd0);
         cnt_in  = 8'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!cnt_ff[7]) begin
            rem_in = ge ? 64'(rem2 - {1'b0, den_ff}) : rem2[63:0];
            dvd_in = {dvd_ff[126:0], 1'b0};
            q_in   = {q_ff[62:0], ge};
            // quotient bits above bit 63 mean overflow
            ovf_in = ovf_ff | (ge & ~cnt_ff[6]);
            cnt_in = cnt_ff + 8'd1;
         end else begin
            res_in  = zero_ff ? 64'd0 : kcaf_sat(q_ff, neg_ff, ovf_ff);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

// ----- tb/sv/kcaf_checker.sv -----
// ----------------------------------------------------------------------------
// kcaf_checker
// Watches the csr, req and rsp channels of the Kalman filter, runs a
// Q23.40 filter model of its own and compares every rsp transfer with it.
// ----------------------------------------------------------------------------
module kcaf_checker
   import kcaf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [31:0]            req_raw_position,
   input  logic [31:0]            req_time_step,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [31:0]            rsp_filtered_position,
   input  logic [31:0]            rsp_filtered_velocity,
   input  logic                   rsp_result_valid,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [KCAF_CSR_IW-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output int                     fail_count,
   output int                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [63:0] q40_type;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] velocity;
      logic        ok;
   } estimate_type;

   estimate_type estimate_q[$];
   int           errors;

   logic [31:0] w_reg, v_reg, step_reg;
   logic        en_reg, seed_pending;
   q40_type     x_pos, x_vel, x_acc;
   q40_type     cov[6];

   function automatic logic [63:0] q40_mag(input q40_type a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic q40_type q40_sat(input logic [63:0] mag, input logic neg,
                                       input logic ovf);
      if (!neg) return (ovf || mag[63]) ? q40_type'(FX_MAX) : q40_type'(mag);
      return (ovf || mag[63]) ? q40_type'(FX_MIN) : q40_type'(~mag + 64'd1);
   endfunction

   function automatic q40_type q40_add(input q40_type a, input q40_type b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? q40_type'(FX_MIN) : q40_type'(FX_MAX);
      return q40_type'(s[63:0]);
   endfunction

   function automatic q40_type q40_sub(input q40_type a, input q40_type b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? q40_type'(FX_MIN) : q40_type'(FX_MAX);
      return q40_type'(s[63:0]);
   endfunction

   // full product, round half away from zero on magnitudes
   function automatic q40_type q40_mul(input q40_type a, input q40_type b);
      logic [127:0] p;
      logic [87:0]  r;
      p = {64'd0, q40_mag(a)} * {64'd0, q40_mag(b)} + (128'd1 << 39);
      r = p[127:40];
      return q40_sat(r[63:0], a[63] ^ b[63], |r[87:64]);
   endfunction

   // (a << 40) / b, truncating
   function automatic q40_type q40_div(input q40_type a, input q40_type b);
      logic [127:0] q;
      if (b == 0) return '0;
      q = ({64'd0, q40_mag(a)} << 40) / {64'd0, q40_mag(b)};
      return q40_sat(q[63:0], a[63] ^ b[63], |q[127:64]);
   endfunction

   function automatic logic [31:0] q40_to_q16(input q40_type a);
      logic [64:0] r;
      r = ({1'b0, q40_mag(a)} + 65'd8388608) >> 24;
      if (a[63]) return (r > 65'h80000000) ? 32'h80000000 : (~r[31:0] + 32'd1);
      return (r > 65'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
   endfunction

   task automatic filter_update(input logic [31:0] raw, input logic [31:0] step,
                                output estimate_type res);
      q40_type d, z, d2, d3, d4, d5, w2, v2;
      q40_type q11, q12, q13, q22, q23, q33, t7, t9, p33d;
      q40_type m11, m12, m13, m22, m23, m33, s, pp, vp, e, k1, k2, k3, om;
      res = '0;
      if (!en_reg || w_reg == 0 || v_reg == 0 || step_reg == 0) return;
      if (step == 0) step = step_reg;
      d  = {24'd0, step, 8'd0};
      z  = {{8{raw[31]}}, raw, 24'd0};
      w2 = q40_mul({8'd0, w_reg, 24'd0}, {8'd0, w_reg, 24'd0});
      v2 = q40_mul({8'd0, v_reg, 24'd0}, {8'd0, v_reg, 24'd0});
      d2 = q40_mul(d, d);
      d3 = q40_mul(d2, d);
      d4 = q40_mul(d2, d2);
      d5 = q40_mul(d4, d);
      q11 = q40_mul(q40_mul(d5, FX_TWENTIETH), w2);
      q12 = q40_mul(q40_mul(d4, FX_EIGHTH), w2);
      q13 = q40_mul(q40_mul(d3, FX_SIXTH), w2);
      q22 = q40_mul(q40_mul(d3, FX_THIRD), w2);
      q23 = q40_mul(q40_mul(d2, FX_HALF), w2);
      q33 = q40_mul(d, w2);
      if (seed_pending) begin
         x_pos = z; x_vel = '0; x_acc = '0;
         cov[0] = q11; cov[1] = q12; cov[2] = q13;
         cov[3] = q22; cov[4] = q23; cov[5] = q33;
         seed_pending = 1'b0;
      end
      // predicted covariance
      t7   = q40_mul(cov[4], d);
      p33d = q40_mul(cov[5], d);
      t9   = q40_add(q40_add(cov[2], t7), q40_mul(q40_mul(cov[5], d2), FX_HALF));
      m11  = q40_add(q40_add(q40_add(q40_add(q40_add(cov[0], q40_mul(cov[1], d)),
               q40_mul(q40_mul(d2, t9), FX_HALF)), q40_mul(q40_mul(cov[2], d2), FX_HALF)),
               q11), q40_mul(d, q40_add(q40_add(cov[1], q40_mul(cov[3], d)),
               q40_mul(q40_mul(cov[4], d2), FX_HALF))));
      m12  = q40_add(q40_add(q40_add(q40_add(cov[1], q40_mul(cov[2], d)), q12),
               q40_mul(q40_mul(d2, q40_add(cov[4], p33d)), FX_HALF)),
               q40_mul(d, q40_add(cov[3], t7)));
      m13  = q40_add(t9, q13);
      m22  = q40_add(q40_add(q40_add(cov[3], t7), q40_mul(d, q40_add(cov[4], p33d))), q22);
      m23  = q40_add(q40_add(cov[4], p33d), q23);
      m33  = q40_add(cov[5], q33);
      // predicted state and correction
      pp = q40_add(q40_add(x_pos, q40_mul(d, x_vel)), q40_mul(q40_mul(x_acc, d2), FX_HALF));
      vp = q40_add(x_vel, q40_mul(x_acc, d));
      e  = q40_sub(pp, z);
      s  = q40_add(m11, v2);
      k1 = q40_div(m11, s);
      k2 = q40_div(m12, s);
      k3 = q40_div(m13, s);
      x_pos = q40_sub(pp, q40_mul(e, k1));
      x_vel = q40_sub(vp, q40_mul(e, k2));
      x_acc = q40_sub(x_acc, q40_mul(e, k3));
      om = q40_sub(FX_ONE, k1);
      cov[0] = q40_mul(m11, om);
      cov[1] = q40_mul(m12, om);
      cov[2] = q40_mul(m13, om);
      cov[3] = q40_sub(m22, q40_mul(k2, m12));
      cov[4] = q40_sub(m23, q40_mul(k3, m12));
      cov[5] = q40_sub(m33, q40_mul(k3, m13));
      res.position = q40_to_q16(x_pos);
      res.velocity = q40_to_q16(x_vel);
      res.ok       = 1'b1;
   endtask

   always @(posedge clock) begin
      estimate_type want, got;
      if (reset) begin
         w_reg = '0; v_reg = '0; step_reg = '0; en_reg = 1'b0;
         seed_pending = 1'b1;
         x_pos = '0; x_vel = '0; x_acc = '0;
         foreach (cov[i]) cov[i] = '0;
         estimate_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     begin w_reg = csr_data;       seed_pending = 1'b1; end
               CSR_MEASUREMENT_NOISE: begin v_reg = csr_data;       seed_pending = 1'b1; end
               CSR_DEFAULT_STEP:      begin step_reg = csr_data;    seed_pending = 1'b1; end
               CSR_ENABLE:            begin en_reg = csr_data[0];   seed_pending = 1'b1; end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_filtered_position, rsp_filtered_velocity, rsp_result_valid};
            if (estimate_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected rsp transfer pos=%h vel=%h ok=%b",
                           $realtime, got.position, got.velocity, got.ok);
            end else begin
               want = estimate_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: rsp mismatch pos exp=%h act=%h vel exp=%h act=%h ok exp=%b act=%b",
                              $realtime, want.position, got.position, want.velocity,
                              got.velocity, want.ok, got.ok);
               end
            end
         end
         if (req_valid && !req_stall) begin
            filter_update(req_raw_position, req_time_step, want);
            estimate_q.push_back(want);
         end
      end
      fail_count      <= errors;
      pending_results <= estimate_q.size();
   end

endmodule

// ----- tb/sv/tb_kalman_const_accel_filter_top.sv -----
// ----------------------------------------------------------------------------
// tb_kalman_const_accel_filter_top
// Drives configuration phases and sample streams into the Kalman filter with
// bursty req traffic and patterned rsp stalls; kcaf_checker does the checking.
// ----------------------------------------------------------------------------
module tb_kalman_const_accel_filter_top;
   import kcaf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SAMPLES = 1850;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [31:0]            req_raw_position = '0;
   logic [31:0]            req_time_step = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [31:0]            rsp_filtered_position;
   logic [31:0]            rsp_filtered_velocity;
   logic                   rsp_result_valid;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [KCAF_CSR_IW-1:0] csr_index = '0;
   logic [31:0]            csr_data = '0;

   int fail_count;
   int pending_results;
   int samples_sent = 0;
   int burst_left = 0;

   // trajectory used for well-formed sample streams, Q16.16
   int track_pos = 0;
   int track_vel = 0;

   // 4 ns clock: 2 high, 2 low
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   kalman_const_accel_filter_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_position      (req_raw_position),
      .req_time_step         (req_time_step),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_filtered_position (rsp_filtered_position),
      .rsp_filtered_velocity (rsp_filtered_velocity),
      .rsp_result_valid      (rsp_result_valid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   kcaf_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_position      (req_raw_position),
      .req_time_step         (req_time_step),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_filtered_position (rsp_filtered_position),
      .rsp_filtered_velocity (rsp_filtered_velocity),
      .rsp_result_valid      (rsp_result_valid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .fail_count            (fail_count),
      .pending_results       (pending_results)
   );

   // rsp stall pattern: modes switch, after spans of random length, between
   // no stall, coin-flip stalls and mostly-stalled stretches
   int stall_mode = 0;
   int stall_span = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_span <= 0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span <= $urandom_range(50, 600);
         end else begin
            stall_span <= stall_span - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // one csr transfer; valid stays up so back-to-back writes need no re-raise
   task automatic csr_write(input logic [KCAF_CSR_IW-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_filter(input logic [31:0] w, input logic [31:0] v,
                             input logic [31:0] step, input logic en);
      csr_write(CSR_PROCESS_NOISE, w);
      csr_write(CSR_MEASUREMENT_NOISE, v);
      csr_write(CSR_DEFAULT_STEP, step);
      csr_write(CSR_ENABLE, {31'd0, en});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one req transfer, then maybe a gap when the burst runs out
   task automatic send_sample(input logic [31:0] pos, input logic [31:0] step);
      req_valid        <= 1'b1;
      req_raw_position <= pos;
      req_time_step    <= step;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // block idle: every transfer answered, plus margin for the closed path
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_noise();
      case ($urandom_range(0, 19))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         3:       return 32'd1;
         default: return $urandom_range(32'h100, 32'h40000);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 1000);
         default: return $urandom_range(32'h10_0000, 32'h400_0000);
      endcase
   endfunction

   task automatic random_sample();
      logic [31:0] pos;
      logic [31:0] step;
      case ($urandom_range(0, 9))
         0:       pos = $urandom;
         1:       pos = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: begin
            // smooth track with measurement noise
            track_vel = track_vel + $signed($urandom_range(0, 2000)) - 1000;
            track_pos = track_pos + (track_vel >>> 4);
            pos = track_pos + $signed($urandom_range(0, 65536)) - 32768;
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: step = '0;
         4, 5:       step = $urandom;
         default:    step = $urandom_range(32'h10_0000, 32'h400_0000);
      endcase
      send_sample(pos, step);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // nominal settings: 1.0 noise, ~1 ms default step
      set_filter(32'h1_0000, 32'h1_0000, 32'd4294967, 1'b1);
      send_sample(32'h0000_0000, 32'h0000_0000);     // seeds from measurement
      send_sample(32'h7FFF_FFFF, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0001_0000, 32'h0000_0001);
      send_sample(32'hAAAA_AAAA, 32'h5555_5555);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000);
      drain();
      // closed filter: enable low, then a zero noise and a zero default step
      set_filter(32'h1_0000, 32'h1_0000, 32'd4294967, 1'b0);
      send_sample(32'h1234_5678, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF);
      drain();
      set_filter(32'h0, 32'h1_0000, 32'd4294967, 1'b1);
      send_sample(32'h1234_5678, 32'h0001_0000);
      drain();
      set_filter(32'h1_0000, 32'h1_0000, 32'h0, 1'b1);
      send_sample(32'h1234_5678, 32'h0001_0000);
      drain();
      // tiny settings: zero covariance and tiny v^2 -> zero gains
      set_filter(32'd1, 32'd1, 32'd1, 1'b1);
      send_sample(32'h0010_0000, 32'h0000_0000);
      send_sample(32'hFFF0_0000, 32'h0000_0001);
      send_sample(32'h0000_0001, 32'h0000_0000);
      drain();
      // largest settings: saturating products
      set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0000_0000, 32'h0000_0000);
      drain();
      // unknown register indexes are dropped and must not rearm seeding
      csr_write(8'd4, 32'hFFFF_FFFF);
      csr_write(8'd255, 32'h0);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_sample(32'h0100_0000, 32'h0000_0000);
      send_sample(32'hFF00_0000, 32'h8000_0000);
      drain();

      // ---- random phases ----
      while (samples_sent < NUM_SAMPLES) begin
         int n;
         if ($urandom_range(0, 4) == 0) begin
            // single register write: sets enable and rearms seeding
            csr_write(CSR_ENABLE, {31'd0, ($urandom_range(0, 9) != 0)});
         end else begin
            csr_write(CSR_PROCESS_NOISE, pick_noise());
            csr_write(CSR_MEASUREMENT_NOISE, pick_noise());
            csr_write(CSR_DEFAULT_STEP, pick_step());
            csr_write(CSR_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)),
                                   ($urandom_range(0, 9) != 0)});
         end
         if ($urandom_range(0, 4) == 0)
            csr_write(8'($urandom_range(4, 255)), $urandom);
         csr_valid <= 1'b0;
         @(posedge clock);
         track_pos = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         track_vel = 0;
         burst_left = $urandom_range(0, 12);
         n = $urandom_range(10, 80);
         repeat (n) random_sample();
         drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog for ~1850 updates at 4 ns: a run that outlasts it reports a mismatch
   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
